@@ src/dbq_pkg.sv @@
// shared constants, command and status types for the depth box blur quantizer
package dbq_pkg;

    // default sizes
    localparam int MAX_WIDTH_DEF   = 2048;
    localparam int KERNEL_SIZE_DEF = 7;
    localparam int FRAC_BITS_DEF   = 8;

    // fixed field widths
    localparam int DEPTH_W   = 24;
    localparam int OUT_W     = 17;
    localparam int DIM_REG_W = 12;
    localparam int CFG_IDX_W = 2;

    localparam int MAX_HEIGHT = 2048;
    localparam int STEP_HI    = 10;
    localparam int OUT_MAX    = 131071;

    localparam logic [DIM_REG_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [DIM_REG_W-1:0] HEIGHT_RESET = 12'd480;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    // op codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    typedef struct packed {
        logic take;       // accept an input beat
        logic tap_start;  // clear sum and tap counters
        logic tap_run;    // read one window tap
        logic m_step;     // advance step search
        logic div_load;   // load divider
        logic div_run;    // one divider bit
        logic mul;        // form final result
        logic emit;       // push result to output register
    } dbq_cmd_t;

    typedef struct packed {
        logic emit_pending;
        logic tap_last;
        logic m_done;
        logic div_last;
        logic out_free;
    } dbq_status_t;

endpackage

@@ src/dbq_ctrl.sv @@
// sequencing state machine for the depth box blur quantizer
module dbq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  dbq_pkg::dbq_status_t status,
    output dbq_pkg::dbq_cmd_t    cmd
);
    import dbq_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_DRAIN,
        ST_STEP,
        ST_UNIT,
        ST_DIV,
        ST_MUL,
        ST_LOAD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_stall_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !in_stall_reg)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.tap_start = 1'b1;
                state_next    = status.emit_pending ? ST_READ : ST_IDLE;
            end
            ST_READ:
            begin
                cmd.tap_run = 1'b1;
                if (status.tap_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                cmd.m_step = 1'b1;
                if (status.m_done)
                begin
                    state_next = ST_UNIT;
                end
            end
            ST_UNIT:
            begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_run = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            in_stall_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_stall_reg <= (state_next != ST_IDLE);
        end
    end

    assign in_stall = in_stall_reg;

endmodule

@@ src/dbq_datapath.sv @@
// counters, line store, window sum, step search, divider and output register
module dbq_datapath #(
    parameter int MAX_WIDTH   = dbq_pkg::MAX_WIDTH_DEF,
    parameter int KERNEL_SIZE = dbq_pkg::KERNEL_SIZE_DEF,
    parameter int FRAC_BITS   = dbq_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  dbq_pkg::dbq_cmd_t               cmd,
    output dbq_pkg::dbq_status_t            status,
    input  logic                            op,
    input  logic [dbq_pkg::DEPTH_W-1:0]     depth_in,
    input  logic                            cfg_we,
    input  logic [dbq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dbq_pkg::DIM_REG_W-1:0]   cfg_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [dbq_pkg::OUT_W-1:0]       depth_out,
    output logic                            frame_end
);
    import dbq_pkg::*;

    localparam int HALF      = KERNEL_SIZE / 2;
    localparam int ROWS_KEPT = 2 * HALF + 2;
    localparam int SL_W      = $clog2(ROWS_KEPT);
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int DIM_W     = $clog2(MAX_WIDTH + 1);
    localparam int CW        = (DIM_W > DIM_REG_W) ? DIM_W : DIM_REG_W;
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    localparam int H_W       = $clog2(MAX_HEIGHT + 1);
    localparam int CNT_W     = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int TAP_W     = $clog2(KERNEL_SIZE);
    localparam int NTAP      = KERNEL_SIZE * KERNEL_SIZE;
    localparam int SUM_W     = DEPTH_W + $clog2(NTAP);
    localparam int DEN       = NTAP << FRAC_BITS;
    localparam int UNIT_W    = $clog2(DEN * STEP_HI + 1);
    localparam int M_W       = $clog2(STEP_HI + 1);
    localparam int DC_W      = $clog2(SUM_W);
    localparam int SC_W      = COL_W + 3;
    localparam int SR_W      = ROW_W + 3;
    localparam int SS_W      = SL_W + 2;
    localparam int DIM_LO    = (HALF + 1 > 4) ? HALF + 1 : 4;

    // configuration and clamped sizes
    logic [DIM_REG_W-1:0] frame_width_reg;
    logic [DIM_REG_W-1:0] frame_height_reg;
    logic [DIM_W-1:0]     w;
    logic [H_W-1:0]       h;
    logic [CW-1:0]        fw_ext;
    logic                 restart_cfg;

    // frame counters
    logic [COL_W-1:0] in_col_reg;
    logic [ROW_W-1:0] in_row_reg;
    logic [SL_W-1:0]  in_slot_reg;
    logic [CNT_W-1:0] in_count_reg;
    logic             in_done_reg;
    logic [COL_W-1:0] out_col_reg;
    logic [ROW_W-1:0] out_row_reg;
    logic [SL_W-1:0]  out_slot_reg;
    logic [CNT_W-1:0] out_count_reg;
    logic             emit_reg;

    logic [DIM_W-1:0] in_col_inc;
    logic [H_W-1:0]   in_row_inc;
    logic [DIM_W-1:0] out_col_inc;
    logic [H_W-1:0]   out_row_inc;
    logic [CNT_W-1:0] diff;
    logic [CNT_W-1:0] lag;
    logic             at_last;
    logic             is_sample;

    // window taps
    logic [TAP_W-1:0]       tap_row_reg;
    logic [TAP_W-1:0]       tap_col_reg;
    logic                   rd_pend_reg;
    logic [DEPTH_W-1:0]     rd_data_reg;
    logic [SUM_W-1:0]       acc_reg;
    logic signed [SR_W-1:0] rs;
    logic signed [SR_W-1:0] rm;
    logic signed [SR_W-1:0] rdelta;
    logic signed [SC_W-1:0] cs;
    logic signed [SC_W-1:0] cm;
    logic signed [SS_W-1:0] slot_s;
    logic signed [SS_W-1:0] slot_a;
    logic [SL_W-1:0]        rd_slot;
    logic [COL_W-1:0]       rd_col;

    logic [DEPTH_W-1:0] line_mem [ROWS_KEPT][MAX_WIDTH];

    // quantizer
    logic [M_W-1:0]       m_reg;
    logic [UNIT_W-1:0]    m_den;
    logic [UNIT_W-1:0]    unit_reg;
    logic [UNIT_W-1:0]    rem_reg;
    logic [SUM_W-1:0]     quo_reg;
    logic [DC_W-1:0]      div_cnt_reg;
    logic [UNIT_W:0]      trial;
    logic [SUM_W-1:0]     q_ceil;
    logic [SUM_W+M_W-1:0] prod;
    logic [OUT_W-1:0]     res_reg;

    logic             out_valid_reg;
    logic [OUT_W-1:0] depth_out_reg;
    logic             frame_end_reg;

    always_comb
    begin
        fw_ext = CW'(frame_width_reg);
        if (fw_ext < CW'(DIM_LO))
            w = DIM_W'(DIM_LO);
        else if (fw_ext > CW'(MAX_WIDTH))
            w = DIM_W'(MAX_WIDTH);
        else
            w = DIM_W'(fw_ext);
        if (frame_height_reg < DIM_REG_W'(DIM_LO))
            h = H_W'(DIM_LO);
        else if (H_W'(frame_height_reg) > H_W'(MAX_HEIGHT))
            h = H_W'(MAX_HEIGHT);
        else
            h = H_W'(frame_height_reg);
    end

    assign restart_cfg = cfg_we &&
        (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

    assign in_col_inc  = DIM_W'(in_col_reg) + DIM_W'(1);
    assign in_row_inc  = H_W'(in_row_reg) + H_W'(1);
    assign out_col_inc = DIM_W'(out_col_reg) + DIM_W'(1);
    assign out_row_inc = H_W'(out_row_reg) + H_W'(1);
    assign diff        = in_count_reg + CNT_W'(1) - out_count_reg;
    assign lag         = CNT_W'(w) * CNT_W'(HALF) + CNT_W'(HALF);
    assign at_last     = (out_row_inc == h) && (out_col_inc == w);
    assign is_sample   = (op == OP_SAMPLE) && !in_done_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= WIDTH_RESET;
            frame_height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // input and output position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            in_slot_reg   <= '0;
            in_count_reg  <= '0;
            in_done_reg   <= 1'b0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            out_slot_reg  <= '0;
            out_count_reg <= '0;
            emit_reg      <= 1'b0;
        end
        else if (restart_cfg || (cmd.emit && at_last))
        begin
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            in_slot_reg   <= '0;
            in_count_reg  <= '0;
            in_done_reg   <= 1'b0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            out_slot_reg  <= '0;
            out_count_reg <= '0;
        end
        else
        begin
            if (cmd.take)
            begin
                if (is_sample)
                begin
                    in_count_reg <= in_count_reg + CNT_W'(1);
                    emit_reg     <= diff > lag;
                    if (in_col_inc >= w)
                    begin
                        in_col_reg <= '0;
                        if (in_row_inc >= h)
                        begin
                            in_row_reg  <= '0;
                            in_slot_reg <= '0;
                            in_done_reg <= 1'b1;
                        end
                        else
                        begin
                            in_row_reg  <= ROW_W'(in_row_inc);
                            in_slot_reg <= (in_slot_reg == SL_W'(ROWS_KEPT - 1)) ?
                                           '0 : in_slot_reg + SL_W'(1);
                        end
                    end
                    else
                    begin
                        in_col_reg <= COL_W'(in_col_inc);
                    end
                end
                else
                begin
                    emit_reg <= (op == OP_FLUSH) && in_done_reg;
                end
            end
            if (cmd.emit)
            begin
                out_count_reg <= out_count_reg + CNT_W'(1);
                if (out_col_inc >= w)
                begin
                    out_col_reg  <= '0;
                    out_row_reg  <= ROW_W'(out_row_inc);
                    out_slot_reg <= (out_slot_reg == SL_W'(ROWS_KEPT - 1)) ?
                                    '0 : out_slot_reg + SL_W'(1);
                end
                else
                begin
                    out_col_reg <= COL_W'(out_col_inc);
                end
            end
        end
    end

    // mirrored tap address
    always_comb
    begin
        rs = $signed(SR_W'(out_row_reg)) + $signed(SR_W'(tap_row_reg))
             - $signed(SR_W'(HALF));
        if (rs < 0)
            rm = -rs;
        else if (rs >= $signed(SR_W'(h)))
            rm = $signed(SR_W'({h, 1'b0})) - $signed(SR_W'(2)) - rs;
        else
            rm = rs;
        rdelta = rm - $signed(SR_W'(out_row_reg));
        slot_s = $signed(SS_W'(out_slot_reg)) + $signed(SS_W'(rdelta));
        if (slot_s < 0)
            slot_a = slot_s + $signed(SS_W'(ROWS_KEPT));
        else if (slot_s >= $signed(SS_W'(ROWS_KEPT)))
            slot_a = slot_s - $signed(SS_W'(ROWS_KEPT));
        else
            slot_a = slot_s;
        rd_slot = slot_a[SL_W-1:0];

        cs = $signed(SC_W'(out_col_reg)) + $signed(SC_W'(tap_col_reg))
             - $signed(SC_W'(HALF));
        if (cs < 0)
            cm = -cs;
        else if (cs >= $signed(SC_W'(w)))
            cm = $signed(SC_W'({w, 1'b0})) - $signed(SC_W'(2)) - cs;
        else
            cm = cs;
        rd_col = cm[COL_W-1:0];
    end

    // line store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.take && is_sample)
            line_mem[in_slot_reg][in_col_reg] <= depth_in;
        if (cmd.tap_run)
            rd_data_reg <= line_mem[rd_slot][rd_col];
    end

    // tap sequencing and accumulation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_row_reg <= '0;
            tap_col_reg <= '0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= cmd.tap_run;
            if (cmd.tap_start)
            begin
                tap_row_reg <= '0;
                tap_col_reg <= '0;
            end
            else if (cmd.tap_run)
            begin
                if (tap_col_reg == TAP_W'(KERNEL_SIZE - 1))
                begin
                    tap_col_reg <= '0;
                    tap_row_reg <= tap_row_reg + TAP_W'(1);
                end
                else
                begin
                    tap_col_reg <= tap_col_reg + TAP_W'(1);
                end
            end
        end
    end

    assign m_den = UNIT_W'(m_reg) * UNIT_W'(DEN);
    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign q_ceil = quo_reg + SUM_W'(rem_reg != '0);
    assign prod   = (SUM_W+M_W)'(q_ceil) * (SUM_W+M_W)'(m_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.tap_start)
        begin
            acc_reg <= '0;
            m_reg   <= M_W'(1);
        end
        else if (rd_pend_reg)
        begin
            acc_reg <= acc_reg + SUM_W'(rd_data_reg);
        end
        if (cmd.m_step && !status.m_done)
            m_reg <= m_reg + M_W'(1);
        if (cmd.div_load)
        begin
            unit_reg    <= m_den;
            rem_reg     <= '0;
            quo_reg     <= acc_reg;
            div_cnt_reg <= '0;
        end
        else if (cmd.div_run)
        begin
            // restoring division, one quotient bit a cycle
            if (trial >= {1'b0, unit_reg})
            begin
                rem_reg <= UNIT_W'(trial - {1'b0, unit_reg});
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= UNIT_W'(trial);
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
            end
            div_cnt_reg <= div_cnt_reg + DC_W'(1);
        end
        if (cmd.mul)
            res_reg <= (prod > (SUM_W+M_W)'(OUT_MAX)) ? OUT_W'(OUT_MAX) : OUT_W'(prod);
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            depth_out_reg <= res_reg;
            frame_end_reg <= at_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign depth_out = depth_out_reg;
    assign frame_end = frame_end_reg;

    always_comb
    begin
        status.emit_pending = emit_reg;
        status.tap_last     = (tap_row_reg == TAP_W'(KERNEL_SIZE - 1)) &&
                              (tap_col_reg == TAP_W'(KERNEL_SIZE - 1));
        status.m_done       = (acc_reg <= SUM_W'(m_den)) ||
                              (m_reg == M_W'(STEP_HI));
        status.div_last     = (div_cnt_reg == DC_W'(SUM_W - 1));
        status.out_free     = !out_valid_reg || !out_stall;
    end

`ifndef SYNTHESIS
    a_out_behind_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_count_reg <= in_count_reg)
        else $error("output count ran ahead of input count");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_load |-> (m_reg >= M_W'(1) && m_reg <= M_W'(STEP_HI)))
        else $error("step multiple out of range");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_run |-> rem_reg < unit_reg)
        else $error("divider remainder not below divisor");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && at_last) |=> (in_count_reg == '0 && out_count_reg == '0))
        else $error("counters not cleared after frame end");
`endif

endmodule

@@ src/depth_box_blur_quantize.sv @@
// top level of the streaming depth box blur and step quantizer
// Takes depth samples (unsigned fixed point metres) in raster order and
// returns, per pixel, the KERNEL_SIZE x KERNEL_SIZE mean with mirrored
// borders (edge pixel not repeated), rounded up to a multiple of m whole
// metres, m being the mean's ceiling clamped to 1..10. Outputs lag the input
// by KERNEL_SIZE/2 rows plus KERNEL_SIZE/2 pixels; once a frame's last sample
// is in, each flush beat pushes out one remaining pixel, and frame_end marks
// the last one. Items are handled one at a time: in_stall holds off the next
// input beat until the current one is done. A beat that yields a pixel takes
// longer than one that yields none, because of the single read port of the
// line store (one window tap per cycle), the step search (one compare per
// cycle) and the bit-serial divider (one quotient bit per cycle). The next
// input beat is taken while a finished pixel still waits in the output
// register. Writing frame_width or frame_height restarts the frame; write
// them only while the block is idle. The line store needs no clearing.
module depth_box_blur_quantize #(
    parameter int MAX_WIDTH   = dbq_pkg::MAX_WIDTH_DEF,
    parameter int KERNEL_SIZE = dbq_pkg::KERNEL_SIZE_DEF,
    parameter int FRAC_BITS   = dbq_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            op,
    input  logic [dbq_pkg::DEPTH_W-1:0]     depth_in,
    // output channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [dbq_pkg::OUT_W-1:0]       depth_out,
    output logic                            frame_end,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [dbq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dbq_pkg::DIM_REG_W-1:0]   cfg_data
);
    import dbq_pkg::*;

    // commands down to the datapath, status back up
    dbq_cmd_t    cmd;
    dbq_status_t status;

    // state machine: beat accept, tap reads, step search, divide, load
    dbq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // counters, line store, window sum, quantizer and output register
    dbq_datapath #(
        .MAX_WIDTH   (MAX_WIDTH),
        .KERNEL_SIZE (KERNEL_SIZE),
        .FRAC_BITS   (FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .op        (op),
        .depth_in  (depth_in),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .depth_out (depth_out),
        .frame_end (frame_end)
    );

endmodule
